/* sv/sha_pkg.sv */
// shared constants, types and round functions for the sha-256 message hash
package sha_pkg;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_COMP  = 5'b00100,
    ST_FINAL = 5'b01000,
    ST_OUT   = 5'b10000
  } seq_state_t;

  // padding phases, one-hot: marker byte, zero fill, length field
  typedef enum logic [2:0] {
    PH_MARK = 3'b001,
    PH_ZERO = 3'b010,
    PH_LEN  = 3'b100
  } pad_phase_t;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [7:0] PAD_ZERO   = 8'h00;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD  = 3'd7;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // round sigma on a
  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  // round sigma on e
  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // schedule sigma on w[t-15]
  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  // schedule sigma on w[t-2]
  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

/* sv/sha256_message_hash.sv */
// sha-256 message hash: byte stream in, eight digest words out
//
// Input stream: one message byte per transaction. s_axis_tdata carries the
// byte, s_axis_tuser says whether the byte is valid, s_axis_tlast ends the
// message (a last transaction with tuser low ends it with no further byte).
// A byte that does not complete a 64-byte block is taken without a stall; a
// byte that completes one holds s_axis_tready low while the single round
// unit runs the 64 rounds and then the chaining add.
// On a last transaction the block pads itself one byte per cycle (marker,
// zeros, 64-bit length), compresses one or two more blocks, then presents the
// eight digest words on the output stream, word 0 first, m_axis_tuser giving
// the word index and m_axis_tlast marking word 7. The words leave at one
// per cycle while m_axis_tready is high.
// While words wait for the receiver, everything holds and no input is taken.
// After word 7 the chaining hash and length return to their initial values.
// Reset (rst, synchronous) loads the initial hash and empties the block.
module sha256_message_hash
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] has_byte
  input  logic        s_axis_tlast,   // msg_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // digest_last
);

  seq_state_t  state;
  pad_phase_t  phase;
  logic [5:0]  byte_pos;
  logic [63:0] bit_length;
  logic [5:0]  round_count;
  logic [2:0]  out_idx;
  logic        pad_active;
  logic        final_blk;
  logic [31:0] chain_hash [8];
  logic [31:0] work_regs [8];
  logic [511:0] block_words;

  logic        in_take;
  logic        pad_len;
  logic [7:0]  pad_byte;
  logic        put_en;
  logic [7:0]  put_byte;
  logic [31:0] w_cur;
  logic [31:0] sched_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] choose;
  logic [31:0] major;

  // handshake
  assign s_axis_tready = (state == ST_IDLE);
  assign in_take       = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = chain_hash[out_idx];
  assign m_axis_tuser  = out_idx;
  assign m_axis_tlast  = (out_idx == LAST_WORD);

  // padding byte selection
  always_comb begin
    pad_len = (phase != PH_MARK) && (byte_pos >= LEN_POS) &&
              ((phase == PH_LEN) || (byte_pos == LEN_POS));
    if (phase == PH_MARK) begin
      pad_byte = PAD_MARK;
    end else if (pad_len) begin
      pad_byte = bit_length[{~byte_pos[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = PAD_ZERO;
    end
  end

  // byte into the block buffer
  always_comb begin
    put_en   = 1'b0;
    put_byte = s_axis_tdata;
    case (state)
      ST_IDLE: begin
        put_en = in_take & s_axis_tuser;
      end
      ST_PAD: begin
        put_en   = 1'b1;
        put_byte = pad_byte;
      end
      default: begin
        put_en = 1'b0;
      end
    endcase
  end

  // round unit and message schedule, taps on the 16-word window
  always_comb begin
    w_cur     = block_words[511:480];
    sched_new = small_sigma1(block_words[63:32]) + block_words[223:192] +
                small_sigma0(block_words[479:448]) + block_words[511:480];
    choose    = (work_regs[4] & work_regs[5]) ^ (~work_regs[4] & work_regs[6]);
    major     = (work_regs[0] & work_regs[1]) ^ (work_regs[0] & work_regs[2]) ^
                (work_regs[1] & work_regs[2]);
    t1        = work_regs[7] + big_sigma1(work_regs[4]) + choose +
                ROUND_K[round_count] + w_cur;
    t2        = big_sigma0(work_regs[0]) + major;
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= PH_MARK;
      byte_pos    <= '0;
      bit_length  <= '0;
      round_count <= '0;
      out_idx     <= '0;
      pad_active  <= 1'b0;
      final_blk   <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chain_hash[i] <= INIT_HASH[i];
      end
    end else begin
      if (put_en) begin
        byte_pos <= byte_pos + 6'd1;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (s_axis_tuser) begin
              bit_length <= bit_length + 64'd8;
            end
            if (s_axis_tuser && byte_pos == LAST_POS) begin
              state       <= ST_COMP;
              round_count <= '0;
              pad_active  <= s_axis_tlast;
            end else if (s_axis_tlast) begin
              state      <= ST_PAD;
              pad_active <= 1'b1;
            end
          end
        end
        ST_PAD: begin
          if (phase == PH_MARK) begin
            phase <= PH_ZERO;
          end else if (pad_len) begin
            phase <= PH_LEN;
          end
          if (byte_pos == LAST_POS) begin
            state       <= ST_COMP;
            round_count <= '0;
            final_blk   <= pad_len;
          end
        end
        ST_COMP: begin
          round_count <= round_count + 6'd1;
          if (round_count == LAST_ROUND) begin
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          for (int i = 0; i < 8; i++) begin
            chain_hash[i] <= chain_hash[i] + work_regs[i];
          end
          if (!pad_active) begin
            state <= ST_IDLE;
          end else if (final_blk) begin
            state   <= ST_OUT;
            out_idx <= '0;
          end else begin
            state <= ST_PAD;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == LAST_WORD) begin
              state      <= ST_IDLE;
              phase      <= PH_MARK;
              bit_length <= '0;
              pad_active <= 1'b0;
              final_blk  <= 1'b0;
              for (int i = 0; i < 8; i++) begin
                chain_hash[i] <= INIT_HASH[i];
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath: block shift register and working variables
  always_ff @(posedge clk) begin
    if (put_en) begin
      block_words <= {block_words[503:0], put_byte};
      if (byte_pos == LAST_POS) begin
        for (int i = 0; i < 8; i++) begin
          work_regs[i] <= chain_hash[i];
        end
      end
    end else if (state == ST_COMP) begin
      block_words  <= {block_words[479:0], sched_new};
      work_regs[7] <= work_regs[6];
      work_regs[6] <= work_regs[5];
      work_regs[5] <= work_regs[4];
      work_regs[4] <= work_regs[3] + t1;
      work_regs[3] <= work_regs[2];
      work_regs[2] <= work_regs[1];
      work_regs[1] <= work_regs[0];
      work_regs[0] <= t1 + t2;
    end
  end

`ifndef SYNTHESIS
  // never take input while the digest is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while digest pending");

  // digest starts at word 0 on a fresh block boundary
  a_out_start: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> (out_idx == 3'd0) && (byte_pos == 6'd0))
    else $error("digest started mid-block or mid-word");

  // last round is followed by the chaining add
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMP) && (round_count == LAST_ROUND) |=> (state == ST_FINAL))
    else $error("compression did not end after 64 rounds");

  // after the final word the block is ready for the next message
  a_ready_after: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
      s_axis_tready && (bit_length == 64'd0))
    else $error("not ready for next message");
`endif

endmodule
